// ----- rtl/sle_pkg.sv -----
// Shared types and constants for the serial line editor.
// Transfer payload structs, control character codes, echo action codes.
// No dependencies.
package sle_pkg;

    typedef struct packed {
        logic       operation;
        logic [7:0] rx_char;
        logic [2:0] stream_id;
    } in_t;

    typedef struct packed {
        logic       refused;
        logic       bad_stream;
        logic [2:0] echo_action;
        logic [7:0] echo_char;
        logic [5:0] erase_count;
        logic [7:0] read_char;
        logic       read_valid;
        logic       line_drained;
    } out_t;

    localparam logic OP_RX   = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [2:0] STREAM_MAX = 3'd2;

    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_DEL    = 8'h7f;
    localparam logic [7:0] CH_WERASE = 8'h17;
    localparam logic [7:0] CH_KILL   = 8'h15;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_NL     = 8'h0a;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    localparam logic [2:0] ACT_NONE  = 3'd0;
    localparam logic [2:0] ACT_ECHO  = 3'd1;
    localparam logic [2:0] ACT_BELL  = 3'd2;
    localparam logic [2:0] ACT_CRLF  = 3'd3;
    localparam logic [2:0] ACT_ERASE = 3'd4;

    localparam logic [5:0] ERASE_MAX = 6'd63;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

endpackage

// ----- rtl/sle_ring_mem.sv -----
// Character ring storage: one write port, one read port, registered read data.
// No package dependencies.
module sle_ring_mem #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [7:0]        wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [7:0]        rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // read data holds until the next read, so a waiting consumer sees it stable
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/sle_editor.sv -----
// Line editor sequencer: pointers, line-ready flag and the per-item state machine.
// Drives the ring memory ports; depends on sle_pkg.
module sle_editor import sle_pkg::*; #(
    parameter int RING_DEPTH = 64,
    parameter int PTR_W      = 6
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  in_t              req,
    output logic             busy,
    output logic             res_valid,
    input  logic             res_ready,
    output out_t             res,
    output logic             mem_we,
    output logic [PTR_W-1:0] mem_waddr,
    output logic [7:0]       mem_wdata,
    output logic             mem_re,
    output logic [PTR_W-1:0] mem_raddr,
    input  logic [7:0]       mem_rdata
);

    localparam int CNT_W = (PTR_W > 6) ? PTR_W : 6;
    localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(RING_DEPTH - 1);
    localparam logic [PTR_W-1:0] FULL_LEN = PTR_W'(RING_DEPTH - 2);
    localparam logic [PTR_W:0]   DEPTH_X  = (PTR_W + 1)'(RING_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RDATA,
        S_WSTEP
    } state_t;

    state_t           state_reg, state_next;
    in_t              item_reg;
    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic             ready_reg, ready_next;
    logic [PTR_W-1:0] cnt_reg, cnt_next;

    logic [PTR_W:0]   diff;
    logic [PTR_W-1:0] len;
    logic [PTR_W-1:0] wprev;
    logic [PTR_W-1:0] cnt_inc;

    function automatic logic [PTR_W-1:0] pos_next(input logic [PTR_W-1:0] p);
        return (p == LAST_POS) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] pos_prev(input logic [PTR_W-1:0] p);
        return (p == '0) ? LAST_POS : p - 1'b1;
    endfunction

    function automatic logic [5:0] sat_count(input logic [PTR_W-1:0] n);
        logic [CNT_W-1:0] x;
        x = CNT_W'(n);
        return (x > CNT_W'(ERASE_MAX)) ? ERASE_MAX : x[5:0];
    endfunction

    // pending length, ring-wrapped
    always_comb
    begin
        diff = {1'b0, wp_reg} - {1'b0, rp_reg};
        if (wp_reg < rp_reg)
        begin
            diff = diff + DEPTH_X;
        end
        len = diff[PTR_W-1:0];
    end

    assign wprev   = pos_prev(wp_reg);
    assign cnt_inc = cnt_reg + 1'b1;
    assign busy    = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        wp_next    = wp_reg;
        rp_next    = rp_reg;
        ready_next = ready_reg;
        cnt_next   = cnt_reg;
        res        = '0;
        res_valid  = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = wp_reg;
        mem_wdata  = item_reg.rx_char;
        mem_re     = 1'b0;
        mem_raddr  = rp_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                if (item_reg.operation == OP_RX)
                begin
                    if (ready_reg)
                    begin
                        res.refused = 1'b1;
                        res_valid   = 1'b1;
                    end
                    else
                    begin
                        unique case (item_reg.rx_char) inside
                            CH_CR:
                            begin
                                mem_we          = 1'b1;
                                mem_wdata       = CH_NL;
                                wp_next         = pos_next(wp_reg);
                                ready_next      = 1'b1;
                                res.echo_action = ACT_CRLF;
                                res_valid       = 1'b1;
                            end
                            CH_BS, CH_DEL:
                            begin
                                if (len == '0)
                                begin
                                    res.echo_action = ACT_BELL;
                                end
                                else
                                begin
                                    wp_next         = wprev;
                                    res.echo_action = ACT_ERASE;
                                    res.erase_count = 6'd1;
                                end
                                res_valid = 1'b1;
                            end
                            CH_WERASE:
                            begin
                                cnt_next = '0;
                                if (len == '0)
                                begin
                                    res_valid = 1'b1;
                                end
                                else
                                begin
                                    mem_re     = 1'b1;
                                    mem_raddr  = wprev;
                                    state_next = S_WSTEP;
                                end
                            end
                            CH_KILL:
                            begin
                                wp_next = rp_reg;
                                if (len != '0)
                                begin
                                    res.echo_action = ACT_ERASE;
                                    res.erase_count = sat_count(len);
                                end
                                res_valid = 1'b1;
                            end
                            default:
                            begin
                                // keep one slot free so the newline always fits
                                if (len >= FULL_LEN)
                                begin
                                    res.echo_action = ACT_BELL;
                                end
                                else
                                begin
                                    mem_we          = 1'b1;
                                    wp_next         = pos_next(wp_reg);
                                    res.echo_action = ACT_ECHO;
                                    res.echo_char   = item_reg.rx_char;
                                end
                                res_valid = 1'b1;
                            end
                        endcase
                    end
                end
                else
                begin
                    if (item_reg.stream_id > STREAM_MAX)
                    begin
                        res.bad_stream = 1'b1;
                        res_valid      = 1'b1;
                    end
                    else if (!ready_reg || len == '0)
                    begin
                        res_valid = 1'b1;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = rp_reg;
                        state_next = S_RDATA;
                    end
                end
            end

            S_RDATA:
            begin
                res.read_char  = mem_rdata;
                res.read_valid = 1'b1;
                rp_next        = pos_next(rp_reg);
                if (pos_next(rp_reg) == wp_reg)
                begin
                    ready_next       = 1'b0;
                    res.line_drained = 1'b1;
                end
                res_valid = 1'b1;
            end

            S_WSTEP:
            begin
                // mem_rdata holds the character just before the cursor
                if (is_blank(mem_rdata))
                begin
                    if (cnt_reg != '0)
                    begin
                        res.echo_action = ACT_ERASE;
                        res.erase_count = sat_count(cnt_reg);
                    end
                    res_valid = 1'b1;
                end
                else
                begin
                    wp_next  = wprev;
                    cnt_next = cnt_inc;
                    if (wprev == rp_reg)
                    begin
                        res.echo_action = ACT_ERASE;
                        res.erase_count = sat_count(cnt_inc);
                        res_valid       = 1'b1;
                    end
                    else
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = pos_prev(wprev);
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (res_valid)
        begin
            state_next = S_IDLE;
            // output slot taken: hold everything and retry next cycle
            if (!res_ready)
            begin
                state_next = state_reg;
                wp_next    = wp_reg;
                rp_next    = rp_reg;
                ready_next = ready_reg;
                cnt_next   = cnt_reg;
                mem_we     = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wp_reg    <= '0;
            rp_reg    <= '0;
            ready_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            ready_reg <= ready_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && req_valid)
        begin
            item_reg <= req;
        end
    end

endmodule

// ----- rtl/serial_line_editor_core.sv -----
// Serial line editor top level: editor sequencer, ring memory and output register.
// Depends on sle_pkg, sle_ring_mem, sle_editor.
//
// Terminal line editor over a RING_DEPTH-entry character ring held in one
// synchronous RAM. Items are handled one at a time: an ordinary character,
// return, backspace or ^U is finished in the execute state; a read request
// that pops a character adds a state for the RAM read; ^W makes one RAM
// read per step, stepping back one character at a time until it meets a
// blank or the start of the line (an empty line needs no read at all).
// The result sits in an output register, so the next item is taken while
// the previous result is still stalled. No clearing pass: the ring is
// never read at an entry that has not been written.
module serial_line_editor_core import sle_pkg::*; #(
    parameter int RING_DEPTH = 64
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  in_t  req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output out_t rsp
);

    localparam int PTR_W = $clog2(RING_DEPTH);

    logic             res_valid;
    logic             res_ready;
    out_t             res;
    logic             mem_we;
    logic [PTR_W-1:0] mem_waddr;
    logic [7:0]       mem_wdata;
    logic             mem_re;
    logic [PTR_W-1:0] mem_raddr;
    logic [7:0]       mem_rdata;
    logic             busy;

    logic rsp_valid_reg;
    out_t rsp_reg;

    sle_ring_mem #(
        .DEPTH  (RING_DEPTH),
        .ADDR_W (PTR_W)
    ) u_ring (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    sle_editor #(
        .RING_DEPTH (RING_DEPTH),
        .PTR_W      (PTR_W)
    ) u_editor (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .busy      (busy),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    assign req_stall = busy;
    assign res_ready = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            rsp_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ----- rtl/sle_checker.sv -----
// Port-level checks for serial_line_editor_core, bound to every instance.
// Depends on sle_pkg and serial_line_editor_core.
module sle_checker import sle_pkg::*; (
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_stall,
    input in_t  req,
    input logic rsp_valid,
    input logic rsp_stall,
    input out_t rsp
);

    // a stalled result stays put
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled result changed");

    // one item at a time: a transfer in closes the input for the next cycle
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("input open right after a transfer");

    // a popped character carries no echo and no refusal
    a_read_alone: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.read_valid |->
            rsp.echo_action == ACT_NONE && !rsp.refused && !rsp.bad_stream)
        else $error("read result mixed with receive fields");

    a_drain_read: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.line_drained |-> rsp.read_valid)
        else $error("drain without a popped character");

endmodule

bind serial_line_editor_core sle_checker u_sle_checker (.*);

// ----- tb/serial_line_editor_core_test.sv -----
// Self-checking testbench for serial_line_editor_core: edit, echo, line-ready and read behavior.
// Random valid/stall traffic on both sides, checked against an in-bench line editor model.
// Depends on sle_pkg and the serial_line_editor_core RTL.
`timescale 1ns / 100ps

module serial_line_editor_core_test;
    import sle_pkg::*;

    localparam int DEPTH       = 64;
    localparam int PW          = $clog2(DEPTH);
    localparam int QUIET_LIMIT = 3000;
    localparam int CALM_TAIL   = 80;  // no idling once this few items are left
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic after_drain;  // sender waits for all results before this one
        in_t  item;
    } queued_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    in_t  req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    out_t rsp;

    queued_t    pending_reqs[$];
    out_t       results_due[$];
    logic       pause_next = 1'b0;
    logic       req_took   = 1'b0;
    int         items_in   = 0;
    int         mismatches = 0;
    int         quiet_cycles = 0;
    int         gap_left   = 0;
    int         stall_left = 0;
    int         hold_left  = 0;
    logic       held_once  = 1'b0;

    // line editor state as the block should hold it
    logic [7:0]    ed_ring[DEPTH];
    logic [PW-1:0] ed_wr    = '0;
    logic [PW-1:0] ed_rd    = '0;
    logic          ed_ready = 1'b0;

    serial_line_editor_core #(.RING_DEPTH(DEPTH)) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic separates_words(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic out_t edit_line(input in_t it);
        out_t          r;
        logic [PW-1:0] used;
        logic [PW-1:0] back;
        int unsigned   n;
        r    = '0;
        n    = 0;
        used = ed_wr - ed_rd;
        if (it.operation == OP_RX)
        begin
            if (ed_ready)
            begin
                r.refused = 1'b1;
            end
            else if (it.rx_char == CH_CR)
            begin
                ed_ring[ed_wr] = CH_NL;
                ed_wr          = ed_wr + 1'b1;
                ed_ready       = 1'b1;
                r.echo_action  = ACT_CRLF;
            end
            else if (it.rx_char == CH_BS || it.rx_char == CH_DEL)
            begin
                if (used == 0)
                begin
                    r.echo_action = ACT_BELL;
                end
                else
                begin
                    ed_wr = ed_wr - 1'b1;
                    n     = 1;
                end
            end
            else if (it.rx_char == CH_WERASE)
            begin
                back = ed_wr - 1'b1;
                while (ed_wr != ed_rd && !separates_words(ed_ring[back]))
                begin
                    ed_wr = back;
                    back  = ed_wr - 1'b1;
                    n++;
                end
            end
            else if (it.rx_char == CH_KILL)
            begin
                n     = used;
                ed_wr = ed_rd;
            end
            else if (used >= DEPTH - 2)
            begin
                // keep room for the newline of return
                r.echo_action = ACT_BELL;
            end
            else
            begin
                ed_ring[ed_wr] = it.rx_char;
                ed_wr          = ed_wr + 1'b1;
                r.echo_action  = ACT_ECHO;
                r.echo_char    = it.rx_char;
            end
            if (n != 0)
            begin
                r.echo_action = ACT_ERASE;
                r.erase_count = (n > ERASE_MAX) ? ERASE_MAX : 6'(n);
            end
        end
        else if (it.stream_id > STREAM_MAX)
        begin
            r.bad_stream = 1'b1;
        end
        else if (ed_ready && used != 0)
        begin
            r.read_char  = ed_ring[ed_rd];
            r.read_valid = 1'b1;
            ed_rd        = ed_rd + 1'b1;
            if (ed_wr == ed_rd)
            begin
                ed_ready       = 1'b0;
                r.line_drained = 1'b1;
            end
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic push_item(input logic op, input logic [7:0] c, input logic [2:0] s);
        queued_t q;
        q.after_drain    = pause_next;
        q.item.operation = op;
        q.item.rx_char   = c;
        q.item.stream_id = s;
        pending_reqs.push_back(q);
        pause_next = 1'b0;
    endtask

    task automatic push_rx(input logic [7:0] c);
        push_item(OP_RX, c, 3'($urandom_range(0, 7)));
    endtask

    task automatic push_read(input logic [2:0] s);
        push_item(OP_READ, 8'($urandom_range(0, 255)), s);
    endtask

    function automatic logic [7:0] line_char();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 58)
            return 8'($urandom_range(8'h21, 8'h7e));
        else if (pick < 70)
            return CH_SPACE;
        else if (pick < 74)
            return 8'($urandom_range(CH_TAB, CH_CR - 1));
        else if (pick < 78)
            return CH_BS;
        else if (pick < 81)
            return CH_DEL;
        else if (pick < 86)
            return CH_WERASE;
        else if (pick < 88)
            return CH_KILL;
        return 8'($urandom_range(0, 255));
    endfunction

    // one typed line, usually a return, maybe some refused keys, then reads to drain it
    task automatic queue_line();
        int len;
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 70) : $urandom_range(0, 12);
        for (int i = 0; i < len; i++)
            push_rx(line_char());
        if ($urandom_range(0, 9) != 0)
            push_rx(CH_CR);
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) push_rx(8'($urandom_range(0, 255)));
        for (int i = 0; i < len + 2; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                push_read(3'($urandom_range(STREAM_MAX + 1, 7)));
            push_read(3'($urandom_range(0, STREAM_MAX)));
        end
    endtask

    // request side
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else if (!req_valid || req_took)
        begin
            if (gap_left != 0)
            begin
                gap_left  <= gap_left - 1;
                req_valid <= 1'b0;
            end
            else if (pending_reqs.size() == 0 ||
                     (pending_reqs[0].after_drain && results_due.size() != 0))
            begin
                req_valid <= 1'b0;
            end
            else
            begin
                req       <= pending_reqs[0].item;
                req_valid <= 1'b1;
                pending_reqs.pop_front();
                if (pending_reqs.size() > CALM_TAIL && $urandom_range(0, 7) == 0)
                    gap_left <= $urandom_range(1, 15);
            end
        end
    end

    // response side stall: one long hold, plus random bursts
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
        end
        else if (!held_once && items_in >= 120)
        begin
            held_once <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            rsp_stall  <= 1'b1;
        end
        else if (pending_reqs.size() > CALM_TAIL && $urandom_range(0, 9) == 0)
        begin
            stall_left <= $urandom_range(0, 14);
            rsp_stall  <= 1'b1;
        end
        else
        begin
            rsp_stall <= 1'b0;
        end
    end

    // check results, then predict for the request transfer at this edge
    always @(posedge clk)
    begin
        out_t want;
        if (!rst_n)
        begin
            req_took <= 1'b0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (results_due.size() == 0)
                begin
                    $error("result transfer with nothing outstanding: %h", rsp);
                    mismatches++;
                end
                else
                begin
                    want = results_due.pop_front();
                    check_field("refused",      8'(want.refused),      8'(rsp.refused));
                    check_field("bad_stream",   8'(want.bad_stream),   8'(rsp.bad_stream));
                    check_field("echo_action",  8'(want.echo_action),  8'(rsp.echo_action));
                    check_field("echo_char",    want.echo_char,        rsp.echo_char);
                    check_field("erase_count",  8'(want.erase_count),  8'(rsp.erase_count));
                    check_field("read_char",    want.read_char,        rsp.read_char);
                    check_field("read_valid",   8'(want.read_valid),   8'(rsp.read_valid));
                    check_field("line_drained", 8'(want.line_drained), 8'(rsp.line_drained));
                end
            end
            req_took <= req_valid && !req_stall;
            if (req_valid && !req_stall)
            begin
                results_due.push_back(edit_line(req));
                items_in <= items_in + 1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("serial_line_editor_core_test: done, errors");
                $finish;
            end
        end
    end

    initial
    begin
        // directed: empty-ring edits, bad streams, word erase stopping at a blank,
        // kill, return, refused key, reads down to the drain and past it
        push_read(3'd0);
        push_read(3'd7);
        push_rx(CH_BS);
        push_rx(CH_DEL);
        push_rx(CH_WERASE);
        push_rx(CH_KILL);
        push_rx(8'h00);
        push_rx(8'hff);
        push_rx("a");
        push_rx(CH_SPACE);
        push_rx("b");
        push_rx("c");
        push_rx(CH_WERASE);
        push_rx(CH_WERASE);
        push_rx(CH_DEL);
        push_rx(CH_TAB);
        push_rx("x");
        push_rx(CH_KILL);
        push_rx("z");
        push_rx(CH_CR);
        push_item(OP_RX, "q", 3'd5);
        push_read(3'd3);
        push_read(3'd1);
        push_read(3'd2);
        push_read(3'd0);

        pause_next = 1'b1;
        while (pending_reqs.size() < 600)
        begin
            if ($urandom_range(0, 9) == 0)
                pause_next = 1'b1;
            if ($urandom_range(0, 5) == 0)
            begin
                repeat ($urandom_range(3, 10))
                begin
                    if ($urandom_range(0, 1) == 0)
                        push_rx(8'($urandom_range(0, 255)));
                    else
                        push_read(3'($urandom_range(0, 7)));
                end
            end
            else
            begin
                queue_line();
            end
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_reqs.size() != 0 || req_valid || results_due.size() != 0)
            @(posedge clk);
        repeat (2 * DEPTH + 20) @(posedge clk);

        if (mismatches == 0 && results_due.size() == 0)
            $display("serial_line_editor_core_test: done, clean");
        else
            $display("serial_line_editor_core_test: done, errors");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/sle_pkg.sv
rtl/sle_ring_mem.sv
rtl/sle_editor.sv
rtl/serial_line_editor_core.sv
rtl/sle_checker.sv
tb/serial_line_editor_core_test.sv
